[hw/rtl/modexp_pkg.sv]
// Shared types and constants for the modular exponentiation block
package modexp_pkg;

    // width of the data fields on the ports
    localparam int OUT_BITS = 32;

    // sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_REDUCE = 5'b00010,
        ST_SQUARE = 5'b00100,
        ST_MULT   = 5'b01000,
        ST_DONE   = 5'b10000
    } modexp_state_t;

    // request kinds carried on s_tuser
    localparam logic REQ_POWER   = 1'b0;
    localparam logic REQ_INVERSE = 1'b1;

endpackage

[hw/rtl/modular_exponentiation.sv]
// Modular exponentiation: base^exponent mod modulus, bit-serial square and multiply
//
// Input request (s_ channel): s_tdata holds base_value and exponent_value, s_tuser
// the request kind (power, or inverse using modulus minus 2 as exponent).
// Result (m_ channel): m_tdata holds power_result, one result per request.
// The modulus is written through cfg_we / cfg_wdata; the user must write it only
// while the block is idle, as the block itself does not enforce this. One request
// is worked on at a time; s_tready is high only in the idle state. Every modular
// product runs one multiplier bit per cycle through a single shift-add-reduce
// step. The base is first reduced in the same way; the exponent bits are then
// worked from the top, each with a squaring and, for a set bit, a multiply by
// the reduced base. A modulus below two skips the arithmetic and answers 0.
// The result sits in an output register; if the receiver stalls, the block holds
// its finished value until the output register frees up, then returns to idle.
// Reset (aresetn low, synchronous) loads modulus 65537 and empties the block.
module modular_exponentiation
    import modexp_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_we,
    input  logic [OUT_BITS-1:0]   cfg_wdata,
    // request channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [2*OUT_BITS-1:0] s_tdata,   // base_value, exponent_value
    input  logic                  s_tuser,   // req_type
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_BITS-1:0]   m_tdata    // power_result
);

    localparam int CNT_BITS = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);
    localparam logic [OUT_BITS-1:0] MOD_RESET = 32'd65537;

    modexp_state_t state_reg, state_next;

    logic [WORD_BITS-1:0] mod_reg;
    logic [WORD_BITS-1:0] exp_reg, exp_next;
    logic [WORD_BITS-1:0] base_reg, base_next;
    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [WORD_BITS-1:0] prod_reg, prod_next;
    logic [WORD_BITS-1:0] mplr_reg, mplr_next;
    logic [CNT_BITS-1:0]  bit_cnt_reg, bit_cnt_next;
    logic [CNT_BITS-1:0]  exp_cnt_reg, exp_cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_BITS-1:0]  out_data_reg, out_data_next;

    logic [WORD_BITS-1:0] in_base;
    logic [WORD_BITS-1:0] in_exp;
    logic                 in_accept;
    logic                 mod_small;
    logic                 out_free;
    logic [WORD_BITS-1:0] mcand;
    logic [WORD_BITS+1:0] step_sum;
    logic [WORD_BITS+1:0] mod_x1;
    logic [WORD_BITS+1:0] mod_x2;
    logic [WORD_BITS-1:0] step_val;

    assign in_base   = WORD_BITS'(s_tdata[OUT_BITS-1:0]);
    assign in_exp    = WORD_BITS'(s_tdata[2*OUT_BITS-1:OUT_BITS]);
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign mod_small = (mod_reg < WORD_BITS'(2));
    assign out_free  = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // multiplicand for the running product
    always_comb begin
        case (state_reg)
            ST_REDUCE: mcand = WORD_BITS'(1);
            ST_SQUARE: mcand = acc_reg;
            ST_MULT:   mcand = base_reg;
            default:   mcand = '0;
        endcase
    end

    // one shift-add-reduce step: (2p + bit * a) mod m, with p, a below m
    always_comb begin
        step_sum = {1'b0, prod_reg, 1'b0}
                 + (mplr_reg[WORD_BITS-1] ? {2'b00, mcand} : '0);
        mod_x1   = {2'b00, mod_reg};
        mod_x2   = {1'b0, mod_reg, 1'b0};
        if (step_sum >= mod_x2) begin
            step_val = WORD_BITS'(step_sum - mod_x2);
        end else if (step_sum >= mod_x1) begin
            step_val = WORD_BITS'(step_sum - mod_x1);
        end else begin
            step_val = WORD_BITS'(step_sum);
        end
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        exp_next       = exp_reg;
        base_next      = base_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        mplr_next      = mplr_reg;
        bit_cnt_next   = bit_cnt_reg;
        exp_cnt_next   = exp_cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        // result taken by the receiver
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    prod_next    = '0;
                    mplr_next    = in_base;
                    bit_cnt_next = CNT_LAST;
                    exp_cnt_next = CNT_LAST;
                    exp_next     = (s_tuser == REQ_INVERSE) ? (mod_reg - WORD_BITS'(2))
                                                            : in_exp;
                    if (mod_small) begin
                        acc_next   = '0;
                        state_next = ST_DONE;
                    end else begin
                        acc_next   = WORD_BITS'(1);
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE, ST_SQUARE, ST_MULT: begin
                prod_next    = step_val;
                mplr_next    = mplr_reg << 1;
                bit_cnt_next = bit_cnt_reg - CNT_BITS'(1);
                if (bit_cnt_reg == '0) begin
                    // product complete, set up the next one
                    prod_next    = '0;
                    bit_cnt_next = CNT_LAST;
                    if (state_reg == ST_REDUCE) begin
                        base_next  = step_val;
                        mplr_next  = acc_reg;
                        state_next = ST_SQUARE;
                    end else if (state_reg == ST_SQUARE && exp_reg[WORD_BITS-1]) begin
                        // multiply the new square by the reduced base
                        acc_next   = step_val;
                        mplr_next  = step_val;
                        state_next = ST_MULT;
                    end else begin
                        // exponent bit finished
                        acc_next  = step_val;
                        mplr_next = step_val;
                        exp_next  = exp_reg << 1;
                        if (exp_cnt_reg == '0) begin
                            state_next = ST_DONE;
                        end else begin
                            exp_cnt_next = exp_cnt_reg - CNT_BITS'(1);
                            state_next   = ST_SQUARE;
                        end
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = OUT_BITS'(acc_reg);
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            mod_reg       <= WORD_BITS'(MOD_RESET);
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                mod_reg <= WORD_BITS'(cfg_wdata);
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        exp_reg      <= exp_next;
        base_reg     <= base_next;
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        mplr_reg     <= mplr_next;
        bit_cnt_reg  <= bit_cnt_next;
        exp_cnt_reg  <= exp_cnt_next;
        out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    // an accepted request leaves the idle state at once
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> !s_tready)
        else $error("request accepted but block still idle");

    // a finished result is loaded whenever the output register is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) && out_free |=> m_tvalid && s_tready)
        else $error("finished result not presented");

    // a small modulus skips the arithmetic and answers zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && mod_small |=> (state_reg == ST_DONE) && (acc_reg == '0))
        else $error("small modulus not short-cut to zero");
`endif

endmodule
